/* rtl/enyg_pkg.sv */
// ----------------------------------------------------------------------------
// enyg_pkg
// Shared types, constants and lookup functions for the Ethiopian new year
// to Gregorian date converter.
// ----------------------------------------------------------------------------
package enyg_pkg;

   localparam int YEAR_W   = 14;
   localparam int DAYS_W   = 23;
   localparam int GYEAR_W  = 15;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 56;

   localparam logic [DAYS_W-1:0] GREG_OFFSET = 23'd2006080;
   localparam logic [DAYS_W-1:0] DAYS_400Y   = 23'd146097;
   localparam logic [DAYS_W-1:0] DAYS_100Y   = 23'd36524;
   localparam logic [DAYS_W-1:0] DAYS_4Y     = 23'd1461;
   localparam logic [DAYS_W-1:0] DAYS_1Y     = 23'd365;
   // era offset minus one: previous era year = eth_year + 5499
   localparam logic [GYEAR_W-1:0] ERA_PREV   = 15'd5499;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_OFFS,
      ST_DIV,
      ST_YEAR,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_400,
      PH_100,
      PH_4,
      PH_1
   } phase_type;

   // divisor of each cycle-division phase
   function automatic logic [DAYS_W-1:0] ph_divisor(input phase_type ph);
      logic [DAYS_W-1:0] d;
      case (ph)
         PH_400:  d = DAYS_400Y;
         PH_100:  d = DAYS_100Y;
         PH_4:    d = DAYS_4Y;
         PH_1:    d = DAYS_1Y;
         default: d = DAYS_1Y;
      endcase
      return d;
   endfunction

   // top quotient bit of each phase
   function automatic logic [2:0] ph_top(input phase_type ph);
      logic [2:0] t;
      case (ph)
         PH_400:  t = 3'd5;
         PH_100:  t = 3'd2;
         PH_4:    t = 3'd4;
         PH_1:    t = 3'd2;
         default: t = 3'd2;
      endcase
      return t;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      case (idx)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* rtl/ethiopian_new_year_to_gregorian.sv */
// ----------------------------------------------------------------------------
// ethiopian_new_year_to_gregorian
// Converts an Ethiopian year to facts about its first day and the matching
// Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one Ethiopian year per transaction. rsp_* returns one result
//   transaction per request with the era day count, weekday, Ethiopian leap
//   flag, evangelist and the Gregorian day, month and year.
//   A request is worked by a small sequencer around one shared 24-bit
//   subtractor: the day count (15x9 multiply), the Gregorian offset,
//   17 restoring-division steps over the 400/100/4/1-year cycles, the year
//   sum and leap test, 1 to 12 month-walk steps (one per month reached) and
//   the load of the output register. The sequencer then returns to idle,
//   where the next request is taken.
//   One request is in work at a time and req_tready is low meanwhile.
//   The result sits in an output register, so a new request is taken while
//   a result waits; if the receiver still stalls when the next result is
//   finished, the sequencer holds it until the register frees.
//   Reset (synchronous, active high) returns to idle and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module ethiopian_new_year_to_gregorian
   import enyg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // [13:0] eth_year
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // [22:0] day_count, [25:23] week_day,
                                        // [26] eth_leap, [28:27] evangelist,
                                        // [33:29] greg_day, [37:34] greg_month,
                                        // [51:38] greg_year
);

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [2:0]          step_ff, step_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [DAYS_W-1:0]   days_ff, days_in;
   logic [DAYS_W-1:0]   rem_ff, rem_in;
   logic [5:0]          q400_ff, q400_in;
   logic [2:0]          q100_ff, q100_in;
   logic [4:0]          q4_ff, q4_in;
   logic [2:0]          q1_ff, q1_in;
   logic [GYEAR_W-1:0]  gyear_ff, gyear_in;
   logic                leap_ff, leap_in;
   logic [3:0]          idx_ff, idx_in;
   logic [3:0]          month_ff, month_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   // shared subtractor
   logic [DAYS_W-1:0]   sub_op;
   logic [DAYS_W:0]     diff;
   logic                neg;

   logic [GYEAR_W-1:0]  prev;
   logic [DAYS_W:0]     prod;
   logic [6:0]          t_sum;
   logic [8:0]          s_sum;
   logic [5:0]          oct_sum;
   logic [3:0]          fold2;
   logic [3:0]          fold3;
   logic [2:0]          wday;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      case (state_ff)
         ST_OFFS: sub_op = GREG_OFFSET;
         ST_DIV:  sub_op = ph_divisor(phase_ff) << step_ff;
         ST_WALK: sub_op = {{(DAYS_W-5){1'b0}}, month_len(idx_ff, leap_ff)};
         default: sub_op = GREG_OFFSET;
      endcase
   end

   assign diff = {1'b0, rem_ff} - {1'b0, sub_op};
   assign neg  = diff[DAYS_W];

   assign prev = {1'b0, year_ff} + ERA_PREV;
   assign prod = {{(DAYS_W+1-GYEAR_W){1'b0}}, prev} * (DAYS_W+1)'(365)
               + (DAYS_W+1)'(prev >> 2)
               + (DAYS_W+1)'(prev[1:0] == 2'd3) + (DAYS_W+1)'(1);

   assign t_sum = {q4_ff, 2'b00} + {4'd0, q1_ff} + 7'd1;
   assign s_sum = {6'd0, q100_ff} * 9'd100 + {2'b00, t_sum};

   // day count mod 7 by folding octal digits (8 == 1 mod 7)
   always_comb begin
      oct_sum = {4'd0, days_ff[DAYS_W-1:21]};
      for (int i = 0; i < 7; i++) begin
         oct_sum = oct_sum + {3'd0, days_ff[3*i +: 3]};
      end
      fold2 = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
      fold3 = {3'd0, fold2[3]} + {1'b0, fold2[2:0]};
      wday  = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_MULT;
         ST_MULT: state_in = ST_OFFS;
         ST_OFFS: state_in = ST_DIV;
         ST_DIV:  if (step_ff == 3'd0 && phase_ff == PH_1) state_in = ST_YEAR;
         ST_YEAR: state_in = ST_WALK;
         ST_WALK: if (neg || idx_ff == 4'd11) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      year_in       = year_ff;
      days_in       = days_ff;
      rem_in        = rem_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      q400_in       = q400_ff;
      q100_in       = q100_ff;
      q4_in         = q4_ff;
      q1_in         = q1_ff;
      gyear_in      = gyear_ff;
      leap_in       = leap_ff;
      idx_in        = idx_ff;
      month_in      = month_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            year_in = req_tdata[YEAR_W-1:0];
         end
         ST_MULT: begin
            days_in = prod[DAYS_W-1:0];
            rem_in  = prod[DAYS_W-1:0];
         end
         ST_OFFS: begin
            rem_in   = diff[DAYS_W-1:0];
            phase_in = PH_400;
            step_in  = ph_top(PH_400);
            q400_in  = '0;
            q100_in  = '0;
            q4_in    = '0;
            q1_in    = '0;
         end
         ST_DIV: begin
            if (!neg)
               rem_in = diff[DAYS_W-1:0];
            case (phase_ff)
               PH_400:  q400_in = {q400_ff[4:0], !neg};
               PH_100:  q100_in = {q100_ff[1:0], !neg};
               PH_4:    q4_in   = {q4_ff[3:0], !neg};
               PH_1:    q1_in   = {q1_ff[1:0], !neg};
               default: q1_in   = {q1_ff[1:0], !neg};
            endcase
            if (step_ff == 3'd0) begin
               phase_in = phase_type'(phase_ff + 2'd1);
               step_in  = ph_top(phase_type'(phase_ff + 2'd1));
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ST_YEAR: begin
            gyear_in = {9'd0, q400_ff} * 15'd400 + {6'd0, s_sum};
            leap_in  = ((t_sum[1:0] == 2'd0) && (t_sum != 7'd100)) || (s_sum == 9'd400);
            idx_in   = '0;
            month_in = 4'd1;
         end
         ST_WALK: begin
            if (!neg) begin
               rem_in = diff[DAYS_W-1:0];
               if (idx_ff != 4'd11) begin
                  idx_in   = idx_ff + 4'd1;
                  month_in = month_ff + 4'd1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'd0, gyear_ff[YEAR_W-1:0], month_ff, rem_ff[4:0],
                                2'(year_ff[1:0] + 2'd1), (year_ff[1:0] == 2'd3),
                                wday, days_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff      <= year_in;
      days_ff      <= days_in;
      rem_ff       <= rem_in;
      phase_ff     <= phase_in;
      step_ff      <= step_in;
      q400_ff      <= q400_in;
      q100_ff      <= q100_in;
      q4_ff        <= q4_in;
      q1_ff        <= q1_in;
      gyear_ff     <= gyear_in;
      leap_ff      <= leap_in;
      idx_ff       <= idx_in;
      month_ff     <= month_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

/* bench/ethiopian_new_year_to_gregorian_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ethiopian_new_year_to_gregorian_tb
// Self-checking bench for the Ethiopian new year to Gregorian converter.
// A directed table of years (range ends, years below seven, the top of the
// 14-bit input where the Gregorian year wraps, Gregorian century and leap
// years) is followed by random years under four handshake pressure phases.
// Every response transaction is compared field by field against a hand-worked
// result (first two directed rows) or a behavioral converter kept in the bench.
// ----------------------------------------------------------------------------
module ethiopian_new_year_to_gregorian_tb
   import enyg_pkg::*;
();

   localparam int NUM_DIRECTED     = 24;
   localparam int RANDOM_PER_PHASE = 312;
   localparam int NUM_PHASES       = 4;
   localparam int DRAIN_CYCLES     = 40;

   localparam longint unsigned ERA_BASE    = 5500;
   localparam longint unsigned GREG_SHIFT  = 2006080;
   localparam longint unsigned CYCLE_400Y  = 146097;
   localparam longint unsigned CYCLE_100Y  = 36524;
   localparam longint unsigned CYCLE_4Y    = 1461;
   localparam longint unsigned CYCLE_1Y    = 365;

   typedef struct packed {
      logic [3:0]        pad;
      logic [13:0]       greg_year;
      logic [3:0]        greg_month;
      logic [4:0]        greg_day;
      logic [1:0]        evangelist;
      logic              eth_leap;
      logic [2:0]        week_day;
      logic [DAYS_W-1:0] day_count;
   } date_info_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;  // [13:0] eth_year
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;   // [22:0] day_count, [25:23] week_day,
                                  // [26] eth_leap, [28:27] evangelist,
                                  // [33:29] greg_day, [37:34] greg_month,
                                  // [51:38] greg_year

   bit            row_typed = 1'b0;
   date_info_type row_exp   = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   date_info_type pending_dates[$];
   int            dates_checked  = 0;
   int            mismatch_count = 0;

   logic [YEAR_W-1:0] directed_years [NUM_DIRECTED] = '{
      14'd7, 14'd2016, 14'd9999, 14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
      14'd5, 14'd6, 14'd8, 14'd9, 14'd10, 14'd16383, 14'd16376, 14'd16375,
      14'd1892, 14'd1893, 14'd1992, 14'd1993, 14'd2092, 14'd2015,
      14'h2AAA, 14'h1555
   };
   bit            directed_typed [NUM_DIRECTED];
   date_info_type directed_exp   [NUM_DIRECTED];

   ethiopian_new_year_to_gregorian u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic date_info_type convert_new_year(input logic [YEAR_W-1:0] eth_year);
      date_info_type   d;
      longint unsigned era, prev, days, gdays;
      longint unsigned r400, r100, r4, gyear, rem, len;
      int unsigned     month;
      bit              found;
      era  = ERA_BASE + eth_year;
      prev = era - 1;
      days = prev * 365 + prev / 4;
      if (prev % 4 == 3)
         days = days + 1;
      days  = days + 1;
      gdays = days - GREG_SHIFT;
      r400  = gdays % CYCLE_400Y;
      r100  = r400 % CYCLE_100Y;
      r4    = r100 % CYCLE_4Y;
      gyear = (gdays / CYCLE_400Y) * 400 + (r400 / CYCLE_100Y) * 100
            + (r100 / CYCLE_4Y) * 4 + r4 / CYCLE_1Y + 1;
      rem   = r4 % CYCLE_1Y;
      month = 1;
      found = 1'b0;
      for (int i = 0; i < 12; i++) begin
         if (!found) begin
            case (i)
               1:              len = ((gyear % 4 == 0 && gyear % 100 != 0) ||
                                      gyear % 400 == 0) ? 29 : 28;
               3, 5, 8, 10:    len = 30;
               default:        len = 31;
            endcase
            if (rem < len) begin
               found = 1'b1;
            end else begin
               rem = rem - len;
               if (i < 11)
                  month++;
            end
         end
      end
      d            = '0;
      d.day_count  = days[DAYS_W-1:0];
      d.week_day   = 3'(days % 7);
      d.eth_leap   = ((era + 1) % 4 == 0);
      d.evangelist = 2'(eth_year + 1);
      d.greg_day   = rem[4:0];
      d.greg_month = month[3:0];
      d.greg_year  = gyear[13:0];
      return d;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_year(input logic [YEAR_W-1:0] year, input bit typed,
                            input date_info_type exp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_W-YEAR_W){1'b0}}, year};
      row_typed  = typed;
      row_exp    = exp;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : scoreboard
      date_info_type got;
      date_info_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_dates.push_back(row_typed ? row_exp
                                              : convert_new_year(req_tdata[YEAR_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_dates.size() == 0) begin
               report_mismatch("response with no request pending", got.day_count, 0);
            end else begin
               want = pending_dates.pop_front();
               if (got.day_count != want.day_count)
                  report_mismatch("day_count", got.day_count, want.day_count);
               if (got.week_day != want.week_day)
                  report_mismatch("week_day", got.week_day, want.week_day);
               if (got.eth_leap != want.eth_leap)
                  report_mismatch("eth_leap", got.eth_leap, want.eth_leap);
               if (got.evangelist != want.evangelist)
                  report_mismatch("evangelist", got.evangelist, want.evangelist);
               if (got.greg_day != want.greg_day)
                  report_mismatch("greg_day", got.greg_day, want.greg_day);
               if (got.greg_month != want.greg_month)
                  report_mismatch("greg_month", got.greg_month, want.greg_month);
               if (got.greg_year != want.greg_year)
                  report_mismatch("greg_year", got.greg_year, want.greg_year);
               if (got.pad != want.pad)
                  report_mismatch("padding bits", got.pad, want.pad);
               dates_checked++;
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("[%0t] timeout, %0d responses still pending", $time, pending_dates.size());
      $display("** ethiopian_new_year_to_gregorian: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [YEAR_W-1:0] year;
      foreach (directed_typed[i]) begin
         directed_typed[i] = 1'b0;
         directed_exp[i]   = '0;
      end
      // first rows have hand-worked results: Meskerem 1 of year 7 and 2016
      directed_typed[0] = 1'b1;
      directed_exp[0]   = '{pad: 4'd0, greg_year: 14'd14, greg_month: 4'd8,
                            greg_day: 5'd27, evangelist: 2'd0, eth_leap: 1'b1,
                            week_day: 3'd2, day_count: 23'd2011067};
      directed_typed[1] = 1'b1;
      directed_exp[1]   = '{pad: 4'd0, greg_year: 14'd2023, greg_month: 4'd9,
                            greg_day: 5'd12, evangelist: 2'd1, eth_leap: 1'b0,
                            week_day: 3'd1, day_count: 23'd2744855};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_year(directed_years[i], directed_typed[i], directed_exp[i]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(99) < 85)
               year = YEAR_W'($urandom_range(9999, 7));
            else
               year = YEAR_W'($urandom_range(16383, 0));
            send_year(year, 1'b0, '0);
         end
      end
      req_tvalid = 1'b0;

      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d new-year conversions checked, %0d from the directed table, years over",
               dates_checked, NUM_DIRECTED);
      $display("the full 14-bit input under four sender/receiver pressure phases");
      if (mismatch_count == 0) begin
         $display("** ethiopian_new_year_to_gregorian: PASSED **");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("** ethiopian_new_year_to_gregorian: FAILED **");
      end
      $finish;
   end

endmodule
